>>> rtl/adne_pkg.sv
package adne_pkg;

   // ascii codes used by the echo
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // request kinds carried on tuser
   localparam logic MODE_RX = 1'b0;
   localparam logic MODE_TX = 1'b1;

   // line end phase codes
   localparam logic [1:0] PHASE_FETCH = 2'd0;
   localparam logic [1:0] PHASE_NL    = 2'd1;
   localparam logic [1:0] PHASE_CR    = 2'd2;

   // five bcd digits cover a 16-bit value, 16 shift steps
   localparam int BCD_DIGITS = 5;
   localparam int VALUE_BITS = 16;

   typedef enum logic [1:0] {
      EMIT_DIGIT,
      EMIT_NL,
      EMIT_CR
   } emit_sel_type;

   typedef struct packed {
      logic         rx_step;
      logic         emit;
      emit_sel_type emit_sel;
      logic         phase_set;
      logic [1:0]   phase_value;
      logic         fetch;
      logic         load;
      logic         shift;
      logic         finish;
   } adne_cmd_type;

   typedef struct packed {
      logic       digits_nz;
      logic [1:0] phase;
      logic       queue_nonempty;
      logic       conv_last;
      logic       rsp_busy;
   } adne_status_type;

endpackage

>>> rtl/adne_ctrl.sv
module adne_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_mode,
   output logic                      req_tready,
   input  adne_pkg::adne_status_type status,
   output adne_pkg::adne_cmd_type    cmd
);
   import adne_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_CONV,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && !status.rsp_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd         = '0;
      cmd.emit_sel = EMIT_DIGIT;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_RX)) begin
               cmd.rx_step = 1'b1;
            end else if (accept) begin
               priority if (status.digits_nz) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_DIGIT;
               end else if (status.phase == PHASE_NL) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = EMIT_NL;
                  cmd.phase_set   = 1'b1;
                  cmd.phase_value = PHASE_CR;
               end else if (status.phase == PHASE_CR) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = EMIT_CR;
                  cmd.phase_set   = 1'b1;
                  cmd.phase_value = PHASE_FETCH;
               end else if (status.phase == PHASE_FETCH) begin
                  if (status.queue_nonempty) begin
                     cmd.fetch = 1'b1;
                     state_in  = S_LOAD;
                  end
               end else begin
                  // unused phase code falls back to fetch
                  cmd.phase_set   = 1'b1;
                  cmd.phase_value = PHASE_FETCH;
               end
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_CONV;
         end
         S_CONV: begin
            cmd.shift = 1'b1;
            if (status.conv_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/adne_dpath.sv
module adne_dpath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                rx_byte,
   input  adne_pkg::adne_cmd_type    cmd,
   output adne_pkg::adne_status_type status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata
);
   import adne_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int BW = 4 * BCD_DIGITS;
   localparam int SW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] mem [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [PW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [2:0]            digits_ff, digits_in;
   logic [1:0]            phase_ff, phase_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BW-1:0]         bcd_ff, bcd_in, bcd_adj;
   logic [SW-1:0]         shift_cnt_ff, shift_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic                  is_digit;
   logic                  push;
   logic [7:0]            digit_off;
   logic [3:0]            cur_digit;
   logic [2:0]            digit_count;

   assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit_off = rx_byte - CH_ZERO;
   assign push      = cmd.rx_step && (rx_byte == CH_CR) && (count_ff < CW'(QUEUE_DEPTH));

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   // number of significant digits, at least one
   always_comb begin
      priority if (bcd_ff[19:16] != 4'd0) begin
         digit_count = 3'd5;
      end else if (bcd_ff[15:12] != 4'd0) begin
         digit_count = 3'd4;
      end else if (bcd_ff[11:8] != 4'd0) begin
         digit_count = 3'd3;
      end else if (bcd_ff[7:4] != 4'd0) begin
         digit_count = 3'd2;
      end else begin
         digit_count = 3'd1;
      end
   end

   always_comb begin
      unique case (digits_ff)
         3'd2:    cur_digit = bcd_ff[7:4];
         3'd3:    cur_digit = bcd_ff[11:8];
         3'd4:    cur_digit = bcd_ff[15:12];
         3'd5:    cur_digit = bcd_ff[19:16];
         default: cur_digit = bcd_ff[3:0];
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      phase_in     = phase_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      shift_cnt_in = shift_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.rx_step) begin
         if (is_digit) begin
            acc_in = (acc_ff << 3) + (acc_ff << 1) + {8'd0, digit_off};
         end else begin
            acc_in = '0;
         end
      end
      if (push) begin
         tail_in  = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (cmd.fetch) begin
         head_in  = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_sel)
            EMIT_NL: rsp_data_in = CH_NL;
            EMIT_CR: rsp_data_in = CH_CR;
            default: begin
               rsp_data_in = CH_ZERO + {4'd0, cur_digit};
               digits_in   = digits_ff - 1'b1;
            end
         endcase
      end
      if (cmd.phase_set) begin
         phase_in = cmd.phase_value;
      end
      if (cmd.load) begin
         bin_in       = rd_data_ff;
         bcd_in       = '0;
         shift_cnt_in = '0;
      end
      if (cmd.shift) begin
         bcd_in       = {bcd_adj[BW-2:0], bin_ff[VALUE_BITS-1]};
         bin_in       = {bin_ff[VALUE_BITS-2:0], 1'b0};
         shift_cnt_in = shift_cnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         digits_in = digit_count;
         phase_in  = PHASE_NL;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= acc_ff;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         digits_ff    <= '0;
         phase_ff     <= PHASE_NL;
         shift_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         digits_ff    <= digits_in;
         phase_ff     <= phase_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.digits_nz      = (digits_ff != 3'd0);
   assign status.phase          = phase_ff;
   assign status.queue_nonempty = (count_ff != '0);
   assign status.conv_last      = (shift_cnt_ff == SW'(VALUE_BITS - 1));
   assign status.rsp_busy       = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/ascii_decimal_number_echo.sv
// receive request: done when taken, next request the cycle after if the output register is free
// transmit request that sends a byte: byte shows in the output register in the cycle after
// transmit request that pulls a value: read, load, 16 bcd shift steps, digit count
// outside a value pull, a request waits only while the output register holds an untaken byte
// synchronous active-high reset clears accumulator, queue pointers and count, phase to newline
// queue storage is not cleared by reset
module ascii_decimal_number_echo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tuser,   // [0] mode: 0 received byte, 1 transmitter ready
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] tx_byte
);
   import adne_pkg::*;

   // command and status between controller and datapath
   adne_cmd_type    cmd;
   adne_status_type status;

   // controller: decides what each request does and sequences the conversion
   adne_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: accumulator, value queue, binary to bcd shifter, output register
   adne_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
